// ===== src/rcbd_pkg.sv =====
// Shared types and constants of the remote command byte decoder.
package rcbd_pkg;

	// Item kinds on the input channel
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Joystick frame markers and stick presets
	localparam logic [7:0] FRAME_HEAD = 8'hBB;
	localparam logic [7:0] FRAME_TAIL = 8'hEE;
	localparam logic [7:0] STICK_MID  = 8'd128;
	localparam logic [7:0] STICK_MIN  = 8'd0;
	localparam logic [7:0] STICK_MAX  = 8'd255;

	// Command bytes
	localparam logic [7:0] CMD_STOP        = 8'h30;
	localparam logic [7:0] CMD_FORWARD     = 8'h31;
	localparam logic [7:0] CMD_BACK        = 8'h32;
	localparam logic [7:0] CMD_LEFT        = 8'h33;
	localparam logic [7:0] CMD_RIGHT       = 8'h34;
	localparam logic [7:0] CMD_SERVO_RESET = 8'h37;
	localparam logic [7:0] CMD_AUTO        = 8'h38;
	localparam logic [7:0] CMD_MANUAL      = 8'h39;
	localparam logic [7:0] CMD_BASE_BACK   = 8'h61;
	localparam logic [7:0] CMD_BASE_FRONT  = 8'h62;
	localparam logic [7:0] CMD_ARM_UP      = 8'h63;
	localparam logic [7:0] CMD_ARM_DOWN    = 8'h64;
	localparam logic [7:0] CMD_CLAW_CLOSE  = 8'h65;
	localparam logic [7:0] CMD_CLAW_OPEN   = 8'h66;
	localparam logic [7:0] CMD_ARM_FRONT   = 8'h67;
	localparam logic [7:0] CMD_ARM_BACK    = 8'h68;

	// Drive directions
	localparam logic [2:0] DIR_STOP    = 3'd0;
	localparam logic [2:0] DIR_FORWARD = 3'd1;
	localparam logic [2:0] DIR_BACK    = 3'd2;
	localparam logic [2:0] DIR_LEFT    = 3'd3;
	localparam logic [2:0] DIR_RIGHT   = 3'd4;

	// Servo commands
	localparam logic [2:0] SRV_NONE       = 3'd0;
	localparam logic [2:0] SRV_RESET      = 3'd1;
	localparam logic [2:0] SRV_BASE_BACK  = 3'd2;
	localparam logic [2:0] SRV_BASE_FRONT = 3'd3;
	localparam logic [2:0] SRV_CLAW_CLOSE = 3'd4;
	localparam logic [2:0] SRV_CLAW_OPEN  = 3'd5;
	localparam logic [2:0] SRV_ARM_FRONT  = 3'd6;
	localparam logic [2:0] SRV_ARM_BACK   = 3'd7;

	// Byte buffer: three held bytes plus the one just received
	localparam int BUF_DEPTH = 4;
	localparam logic [2:0] CNT_FULL = 3'd4;

	localparam logic [15:0] TIMEOUT_RESET = 16'd500;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESOLVE,
		ST_PUBLISH
	} state_t;

	typedef struct packed {
		logic load;     // take the accepted item
		logic step;     // resolve the head byte
		logic publish;  // copy state into the output register
	} dp_cmd_t;

	typedef struct packed {
		logic resolve_done;
	} dp_status_t;

endpackage

// ===== src/rcbd_ctrl.sv =====
// Controller state machine of the remote command byte decoder.
module rcbd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	output logic                out_valid,
	input  logic                out_stall,
	input  rcbd_pkg::dp_status_t status,
	output rcbd_pkg::dp_cmd_t    cmd
);
	import rcbd_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (operation == OP_TICK) ? ST_PUBLISH : ST_RESOLVE;
				end
			end
			ST_RESOLVE: begin
				if (status.resolve_done) begin
					state_d = ST_PUBLISH;
				end
			end
			ST_PUBLISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd.load    = 1'b0;
		cmd.step    = 1'b0;
		cmd.publish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_RESOLVE: cmd.step = !status.resolve_done;
			ST_PUBLISH: cmd.publish = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result never overwrites one that is still waiting
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || !out_stall))
		else $error("result published over a stalled result");

	// One item at a time: after an accept the input stalls
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an item is in work");

	// Every publish makes the output valid in the next cycle
	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid_q)
		else $error("published result not shown");

endmodule

// ===== src/rcbd_dp.sv =====
// Datapath of the remote command byte decoder: byte buffer, control state, tick counter.
module rcbd_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  logic                 operation,
	input  logic [7:0]           rx_byte,
	input  logic                 end_of_burst,
	input  rcbd_pkg::dp_cmd_t    cmd,
	output rcbd_pkg::dp_status_t status,
	output logic [2:0]           direction,
	output logic [7:0]           stick_y,
	output logic [7:0]           stick_x,
	output logic                 stick_valid,
	output logic                 manual_mode,
	output logic [2:0]           servo_command,
	output logic                 arm_up_flag,
	output logic                 arm_down_flag,
	output logic                 link_up
);
	import rcbd_pkg::*;

	logic [7:0]  buf_q [BUF_DEPTH];
	logic [2:0]  cnt_q;
	logic        last_q;
	logic [15:0] timeout_q;
	logic [15:0] idle_q, idle_d, idle_inc;
	logic [2:0]  dir_q, dir_d;
	logic [7:0]  joy_y_q, joy_y_d, joy_x_q, joy_x_d;
	logic        seen_q, seen_d;
	logic        manual_q, manual_d;
	logic [2:0]  servo_q, servo_d;
	logic        up_q, up_d, down_q, down_d;
	logic        conn_q, conn_d;
	logic        tick_drop;
	logic        frame_hit;

	assign idle_inc  = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
	assign tick_drop = (idle_inc > timeout_q) && conn_q;
	assign frame_hit = (buf_q[0] == FRAME_HEAD) && (cnt_q == CNT_FULL)
		&& (buf_q[3] == FRAME_TAIL);

	// Stop when empty, or when a frame head waits for more bytes of its burst
	assign status.resolve_done = (cnt_q == 3'd0)
		|| ((buf_q[0] == FRAME_HEAD) && (cnt_q != CNT_FULL) && !last_q);

	always_comb begin
		idle_d   = idle_q;
		dir_d    = dir_q;
		joy_y_d  = joy_y_q;
		joy_x_d  = joy_x_q;
		seen_d   = seen_q;
		manual_d = manual_q;
		servo_d  = servo_q;
		up_d     = up_q;
		down_d   = down_q;
		conn_d   = conn_q;
		if (cmd.load) begin
			if (operation == OP_BYTE) begin
				idle_d = '0;
				conn_d = 1'b1;
			end else begin
				idle_d = idle_inc;
				if (tick_drop) begin
					conn_d  = 1'b0;
					dir_d   = DIR_STOP;
					servo_d = SRV_NONE;
					seen_d  = 1'b0;
					up_d    = 1'b0;
					down_d  = 1'b0;
					joy_y_d = STICK_MID;
					joy_x_d = STICK_MID;
				end
			end
		end else if (cmd.step) begin
			if (buf_q[0] != FRAME_HEAD) begin
				unique case (buf_q[0])
					CMD_STOP: begin
						dir_d = DIR_STOP; joy_y_d = STICK_MID; joy_x_d = STICK_MID;
						seen_d = 1'b1;
					end
					CMD_FORWARD: begin
						dir_d = DIR_FORWARD; joy_y_d = STICK_MIN; joy_x_d = STICK_MID;
						seen_d = 1'b1;
					end
					CMD_BACK: begin
						dir_d = DIR_BACK; joy_y_d = STICK_MAX; joy_x_d = STICK_MID;
						seen_d = 1'b1;
					end
					CMD_LEFT: begin
						dir_d = DIR_LEFT; joy_y_d = STICK_MID; joy_x_d = STICK_MIN;
						seen_d = 1'b1;
					end
					CMD_RIGHT: begin
						dir_d = DIR_RIGHT; joy_y_d = STICK_MID; joy_x_d = STICK_MAX;
						seen_d = 1'b1;
					end
					CMD_SERVO_RESET: servo_d = SRV_RESET;
					CMD_AUTO:        manual_d = 1'b0;
					CMD_MANUAL:      manual_d = 1'b1;
					CMD_BASE_BACK:   if (manual_q) servo_d = SRV_BASE_BACK;
					CMD_BASE_FRONT:  if (manual_q) servo_d = SRV_BASE_FRONT;
					CMD_ARM_UP:      if (manual_q) up_d = 1'b1;
					CMD_ARM_DOWN:    if (manual_q) down_d = 1'b1;
					CMD_CLAW_CLOSE:  if (manual_q) servo_d = SRV_CLAW_CLOSE;
					CMD_CLAW_OPEN:   if (manual_q) servo_d = SRV_CLAW_OPEN;
					CMD_ARM_FRONT:   if (manual_q) servo_d = SRV_ARM_FRONT;
					CMD_ARM_BACK:    if (manual_q) servo_d = SRV_ARM_BACK;
					default: ;
				endcase
			end else if (frame_hit) begin
				joy_y_d = buf_q[1];
				joy_x_d = buf_q[2];
				seen_d  = 1'b1;
			end
		end
	end

	// Byte buffer: append on a byte item, drop the head or a whole frame per step
	always_ff @(posedge clk) begin
		if (cmd.load && (operation == OP_BYTE)) begin
			buf_q[cnt_q[1:0]] <= rx_byte;
		end else if (cmd.step) begin
			for (int i = 0; i < BUF_DEPTH - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			last_q    <= 1'b0;
			timeout_q <= TIMEOUT_RESET;
			idle_q    <= '0;
			dir_q     <= DIR_STOP;
			joy_y_q   <= STICK_MID;
			joy_x_q   <= STICK_MID;
			seen_q    <= 1'b0;
			manual_q  <= 1'b1;
			servo_q   <= SRV_NONE;
			up_q      <= 1'b0;
			down_q    <= 1'b0;
			conn_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (cmd.load && (operation == OP_BYTE)) begin
				cnt_q  <= cnt_q + 3'd1;
				last_q <= end_of_burst;
			end else if (cmd.step) begin
				cnt_q <= frame_hit ? 3'd0 : cnt_q - 3'd1;
			end
			idle_q   <= idle_d;
			dir_q    <= dir_d;
			joy_y_q  <= joy_y_d;
			joy_x_q  <= joy_x_d;
			seen_q   <= seen_d;
			manual_q <= manual_d;
			servo_q  <= servo_d;
			up_q     <= up_d;
			down_q   <= down_d;
			conn_q   <= conn_d;
		end
	end

	// Output register: holds the result while the receiver stalls
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			direction     <= dir_q;
			stick_y       <= joy_y_q;
			stick_x       <= joy_x_q;
			stick_valid   <= seen_q;
			manual_mode   <= manual_q;
			servo_command <= servo_q;
			arm_up_flag   <= up_q;
			arm_down_flag <= down_q;
			link_up       <= conn_q;
		end
	end

	// At most three bytes stay held between items
	a_held_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (cnt_q < CNT_FULL))
		else $error("byte buffer overflow on load");

endmodule

// ===== src/remote_command_byte_decoder.sv =====
// Top level of the remote command byte decoder.
//
// Input channel (in_valid / in_stall): each item is a received byte with its
// end_of_burst mark (operation 0) or one timer tick (operation 1). Output
// channel (out_valid / out_stall): exactly one result per item, the control
// state after that item. cfg_we / cfg_wdata write timeout_ticks.
// From accept to out_valid, a tick goes straight to the publish state; a byte
// first passes through the resolve state, one step for each held byte resolved
// (up to four) and a last pass that sees the buffer settle, then the publish
// state loads the output register. The resolve step handles one head byte
// of the buffer per cycle, and the block works on one item at a time; the next
// item is taken once its result is in the output register.
// A result waiting under out_stall holds in the output register while the
// next item is accepted and worked on; that item's result then waits for the
// register to free. Reset clears the held bytes, centres the sticks, selects
// manual mode, drops the link and sets the timeout to 500 ticks.
module remote_command_byte_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_burst,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  direction,
	output logic [7:0]  stick_y,
	output logic [7:0]  stick_x,
	output logic        stick_valid,
	output logic        manual_mode,
	output logic [2:0]  servo_command,
	output logic        arm_up_flag,
	output logic        arm_down_flag,
	output logic        link_up
);
	import rcbd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	rcbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	rcbd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.operation     (operation),
		.rx_byte       (rx_byte),
		.end_of_burst  (end_of_burst),
		.cmd           (cmd),
		.status        (status),
		.direction     (direction),
		.stick_y       (stick_y),
		.stick_x       (stick_x),
		.stick_valid   (stick_valid),
		.manual_mode   (manual_mode),
		.servo_command (servo_command),
		.arm_up_flag   (arm_up_flag),
		.arm_down_flag (arm_down_flag),
		.link_up       (link_up)
	);

endmodule
